// ===== design/mcd_pkg.sv =====
// Shared constants, reciprocal table and controller/datapath interface types
// for the Mie C/D coefficient unit. No dependencies.
package mcd_pkg;

	localparam int MAX_TERMS = 64;
	localparam int ADDR_W    = $clog2(MAX_TERMS);
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int ENTRY_W   = 128;
	localparam int RECIP_N   = MAX_TERMS + 2;
	localparam int DIV_W     = 41;
	localparam int SUM_W     = 40;
	localparam int RES_W     = 48;

	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	// Rounded reciprocals r(n) = floor((2^30 + floor(n/2)) / n), unsigned Q1.30.
	localparam logic [30:0] RECIP [0:65] = '{
		31'd0,
		31'((ONE_Q30 + 64'd0) / 64'd1),   31'((ONE_Q30 + 64'd1) / 64'd2),
		31'((ONE_Q30 + 64'd1) / 64'd3),   31'((ONE_Q30 + 64'd2) / 64'd4),
		31'((ONE_Q30 + 64'd2) / 64'd5),   31'((ONE_Q30 + 64'd3) / 64'd6),
		31'((ONE_Q30 + 64'd3) / 64'd7),   31'((ONE_Q30 + 64'd4) / 64'd8),
		31'((ONE_Q30 + 64'd4) / 64'd9),   31'((ONE_Q30 + 64'd5) / 64'd10),
		31'((ONE_Q30 + 64'd5) / 64'd11),  31'((ONE_Q30 + 64'd6) / 64'd12),
		31'((ONE_Q30 + 64'd6) / 64'd13),  31'((ONE_Q30 + 64'd7) / 64'd14),
		31'((ONE_Q30 + 64'd7) / 64'd15),  31'((ONE_Q30 + 64'd8) / 64'd16),
		31'((ONE_Q30 + 64'd8) / 64'd17),  31'((ONE_Q30 + 64'd9) / 64'd18),
		31'((ONE_Q30 + 64'd9) / 64'd19),  31'((ONE_Q30 + 64'd10) / 64'd20),
		31'((ONE_Q30 + 64'd10) / 64'd21), 31'((ONE_Q30 + 64'd11) / 64'd22),
		31'((ONE_Q30 + 64'd11) / 64'd23), 31'((ONE_Q30 + 64'd12) / 64'd24),
		31'((ONE_Q30 + 64'd12) / 64'd25), 31'((ONE_Q30 + 64'd13) / 64'd26),
		31'((ONE_Q30 + 64'd13) / 64'd27), 31'((ONE_Q30 + 64'd14) / 64'd28),
		31'((ONE_Q30 + 64'd14) / 64'd29), 31'((ONE_Q30 + 64'd15) / 64'd30),
		31'((ONE_Q30 + 64'd15) / 64'd31), 31'((ONE_Q30 + 64'd16) / 64'd32),
		31'((ONE_Q30 + 64'd16) / 64'd33), 31'((ONE_Q30 + 64'd17) / 64'd34),
		31'((ONE_Q30 + 64'd17) / 64'd35), 31'((ONE_Q30 + 64'd18) / 64'd36),
		31'((ONE_Q30 + 64'd18) / 64'd37), 31'((ONE_Q30 + 64'd19) / 64'd38),
		31'((ONE_Q30 + 64'd19) / 64'd39), 31'((ONE_Q30 + 64'd20) / 64'd40),
		31'((ONE_Q30 + 64'd20) / 64'd41), 31'((ONE_Q30 + 64'd21) / 64'd42),
		31'((ONE_Q30 + 64'd21) / 64'd43), 31'((ONE_Q30 + 64'd22) / 64'd44),
		31'((ONE_Q30 + 64'd22) / 64'd45), 31'((ONE_Q30 + 64'd23) / 64'd46),
		31'((ONE_Q30 + 64'd23) / 64'd47), 31'((ONE_Q30 + 64'd24) / 64'd48),
		31'((ONE_Q30 + 64'd24) / 64'd49), 31'((ONE_Q30 + 64'd25) / 64'd50),
		31'((ONE_Q30 + 64'd25) / 64'd51), 31'((ONE_Q30 + 64'd26) / 64'd52),
		31'((ONE_Q30 + 64'd26) / 64'd53), 31'((ONE_Q30 + 64'd27) / 64'd54),
		31'((ONE_Q30 + 64'd27) / 64'd55), 31'((ONE_Q30 + 64'd28) / 64'd56),
		31'((ONE_Q30 + 64'd28) / 64'd57), 31'((ONE_Q30 + 64'd29) / 64'd58),
		31'((ONE_Q30 + 64'd29) / 64'd59), 31'((ONE_Q30 + 64'd30) / 64'd60),
		31'((ONE_Q30 + 64'd30) / 64'd61), 31'((ONE_Q30 + 64'd31) / 64'd62),
		31'((ONE_Q30 + 64'd31) / 64'd63), 31'((ONE_Q30 + 64'd32) / 64'd64),
		31'((ONE_Q30 + 64'd32) / 64'd65)
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr_a;
		logic [ADDR_W-1:0] rd_addr_b;
		logic [ADDR_W-1:0] k;
		logic [CNT_W-1:0]  p;
		logic              lead_clr;
		logic              lead_mul;
		logic              div_start;
		logic              lead_take;
		logic              sum_clr;
		logic              sum_mul;
		logic              sum_acc;
		logic              fin_mul;
		logic              out_load;
		logic              run_end;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

// ===== design/mcd_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module mcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// ===== design/mcd_datapath.sv =====
// Datapath: coefficient store, four arithmetic lanes (C real/imag, D real/imag),
// lead divider and result register. Depends on mcd_pkg and mcd_ram.
module mcd_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mcd_pkg::cmd_t          cmd,
	output mcd_pkg::stat_t         stat,
	input  logic signed [31:0]     a_real,
	input  logic signed [31:0]     a_imag,
	input  logic signed [31:0]     b_real,
	input  logic signed [31:0]     b_imag,
	input  logic                   result_stall,
	output logic                   result_valid,
	output logic [5:0]             order_index,
	output logic signed [47:0]     c_real,
	output logic signed [47:0]     c_imag,
	output logic signed [47:0]     d_real,
	output logic signed [47:0]     d_imag,
	output logic                   run_end
);

	localparam int DW = mcd_pkg::DIV_W;
	localparam int SW = mcd_pkg::SUM_W;
	localparam int RW = mcd_pkg::RES_W;

	logic [mcd_pkg::ENTRY_W-1:0] wr_data, rd_a, rd_b;

	// Lane u selects the lead/minus operand, v the plus operand.
	function automatic logic signed [31:0] u_of(input logic [127:0] e, input int l);
		logic signed [31:0] r;
		case (l)
			0:       r = e[63:32];
			1:       r = e[31:0];
			2:       r = e[127:96];
			default: r = e[95:64];
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] v_of(input logic [127:0] e, input int l);
		logic signed [31:0] r;
		case (l)
			0:       r = e[127:96];
			1:       r = e[95:64];
			2:       r = e[63:32];
			default: r = e[31:0];
		endcase
		return r;
	endfunction

	assign wr_data = {a_real, a_imag, b_real, b_imag};

	mcd_ram #(.WIDTH(mcd_pkg::ENTRY_W), .DEPTH(mcd_pkg::MAX_TERMS)) u_ram (
		.clk      (clk),
		.wr_en    (cmd.wr_en),
		.wr_addr  (cmd.wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(cmd.rd_addr_a),
		.rd_addr_b(cmd.rd_addr_b),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	logic [6:0]  m;
	logic [12:0] mk_q;
	logic [31:0] w1_q, w2_q;
	logic [6:0]  divisor;
	logic [5:0]  div_cnt_q;

	logic signed [46:0]   lead_prod_q [4];
	logic [DW-1:0]        quo_q [4];
	logic [7:0]           rem_q [4];
	logic                 neg_q [4];
	logic signed [DW:0]   lead_q [4];
	logic signed [63:0]   pa_q [4];
	logic signed [63:0]   pb_q [4];
	logic signed [SW-1:0] sum_q [4];
	logic signed [RW-1:0] fin_q [4];
	logic signed [RW-1:0] res [4];

	assign m       = {cmd.k, 1'b1};
	assign divisor = 7'(cmd.k) + 7'd1;

	// Scale factor for the current order and weight lookup for the current sum index.
	always_ff @(posedge clk) begin
		mk_q <= 13'(m * cmd.k);
		w1_q <= 32'(mcd_pkg::RECIP[cmd.p]) + 32'(mcd_pkg::RECIP[cmd.p + 7'd1]);
		w2_q <= 32'(mcd_pkg::RECIP[cmd.p + 7'd1]) + 32'(mcd_pkg::RECIP[cmd.p + 7'd2]);
	end

	// Divider step counter shared by the four lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= 6'(DW);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 6'd1;
		end
	end

	assign stat.div_busy = (div_cnt_q != '0);

	// Lane arithmetic: lead product and division, weighted sum, final scale.
	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic signed [DW-1:0] y;
		logic [7:0]           trial;
		logic signed [42:0]   fin_sh;
		logic signed [RW:0]   total;

		assign y      = DW'(lead_prod_q[l] >>> 6);
		assign trial  = {rem_q[l][6:0], quo_q[l][DW-1]};
		assign fin_sh = 43'(fin_q[l] >>> 6);
		assign total  = (RW+1)'(lead_q[l]) + (RW+1)'(fin_sh);

		always_comb begin
			if (total[RW] != total[RW-1]) begin
				res[l] = total[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
			end else begin
				res[l] = total[RW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.lead_mul) begin
				lead_prod_q[l] <= 47'(u_of(rd_a, l) * $signed({2'b00, mk_q}));
			end
			if (cmd.div_start) begin
				neg_q[l] <= y[DW-1];
				quo_q[l] <= y[DW-1] ? DW'(-y) : DW'(y);
				rem_q[l] <= '0;
			end else if (div_cnt_q != '0) begin
				if (trial >= {1'b0, divisor}) begin
					rem_q[l] <= trial - {1'b0, divisor};
					quo_q[l] <= {quo_q[l][DW-2:0], 1'b1};
				end else begin
					rem_q[l] <= trial;
					quo_q[l] <= {quo_q[l][DW-2:0], 1'b0};
				end
			end
			if (cmd.lead_clr) begin
				lead_q[l] <= '0;
			end else if (cmd.lead_take) begin
				if (neg_q[l]) begin
					lead_q[l] <= -$signed({1'b0, quo_q[l]})
						- $signed((DW+1)'(rem_q[l] != '0));
				end else begin
					lead_q[l] <= $signed({1'b0, quo_q[l]});
				end
			end
			if (cmd.sum_mul) begin
				pa_q[l] <= $signed({1'b0, w1_q[30:0]}) * v_of(rd_a, l);
				pb_q[l] <= $signed({1'b0, w2_q[30:0]}) * u_of(rd_b, l);
			end
			if (cmd.sum_clr) begin
				sum_q[l] <= '0;
			end else if (cmd.sum_acc) begin
				sum_q[l] <= sum_q[l] + SW'(pa_q[l] >>> 30) - SW'(pb_q[l] >>> 30);
			end
			if (cmd.fin_mul) begin
				fin_q[l] <= RW'(sum_q[l] * $signed({1'b0, m}));
			end
		end
	end

	// Result register; a new word loads once the previous one is taken.
	assign stat.out_free = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			order_index <= cmd.k;
			c_real      <= res[0];
			c_imag      <= res[1];
			d_real      <= res[2];
			d_imag      <= res[3];
			run_end     <= cmd.run_end;
		end
	end

endmodule

// ===== design/mcd_ctrl.sv =====
// Controller: loads coefficient words, then sequences lead, sum and output
// steps for each order k. Depends on mcd_pkg.
module mcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           final_term,
	output logic           item_stall,
	input  mcd_pkg::stat_t stat,
	output mcd_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		IDLE, K_START, LEAD_RD, LEAD_MUL, LEAD_DIV, LEAD_WAIT,
		SUM_RD, SUM_MUL, SUM_ACC, FIN_MUL, FIN_OUT
	} state_t;

	localparam int AW = mcd_pkg::ADDR_W;
	localparam int CW = mcd_pkg::CNT_W;

	state_t        state_q;
	logic [CW-1:0] load_q, n_q, p_q;
	logic [AW-1:0] k_q;
	logic [CW-1:0] k_next;
	logic          room;

	assign item_stall = (state_q != IDLE);
	assign k_next     = CW'(k_q) + CW'(1);
	assign room       = (load_q < CW'(mcd_pkg::MAX_TERMS));

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			load_q  <= '0;
			n_q     <= '0;
			k_q     <= '0;
			p_q     <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (item_valid) begin
						if (final_term) begin
							n_q     <= room ? load_q + CW'(1) : load_q;
							load_q  <= '0;
							k_q     <= '0;
							state_q <= K_START;
						end else if (room) begin
							load_q <= load_q + CW'(1);
						end
					end
				end
				K_START: begin
					p_q <= k_next;
					if (k_q != '0) begin
						state_q <= LEAD_RD;
					end else begin
						state_q <= (k_next < n_q) ? SUM_RD : FIN_MUL;
					end
				end
				LEAD_RD:  state_q <= LEAD_MUL;
				LEAD_MUL: state_q <= LEAD_DIV;
				LEAD_DIV: state_q <= LEAD_WAIT;
				LEAD_WAIT: begin
					if (!stat.div_busy) begin
						state_q <= (k_next < n_q) ? SUM_RD : FIN_MUL;
					end
				end
				SUM_RD:  state_q <= SUM_MUL;
				SUM_MUL: state_q <= SUM_ACC;
				SUM_ACC: begin
					p_q     <= p_q + CW'(2);
					state_q <= (p_q + CW'(2) < n_q) ? SUM_RD : FIN_MUL;
				end
				FIN_MUL: state_q <= FIN_OUT;
				FIN_OUT: begin
					if (stat.out_free) begin
						if (k_next == n_q) begin
							state_q <= IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= K_START;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd           = '0;
		cmd.k         = k_q;
		cmd.p         = p_q;
		cmd.wr_addr   = load_q[AW-1:0];
		cmd.wr_en     = (state_q == IDLE) && item_valid && room;
		cmd.rd_addr_a = (state_q == LEAD_RD) ? k_q - AW'(1) : p_q[AW-1:0] - AW'(1);
		cmd.rd_addr_b = p_q[AW-1:0];
		cmd.lead_clr  = (state_q == K_START);
		cmd.sum_clr   = (state_q == K_START);
		cmd.lead_mul  = (state_q == LEAD_MUL);
		cmd.div_start = (state_q == LEAD_DIV);
		cmd.lead_take = (state_q == LEAD_WAIT) && !stat.div_busy;
		cmd.sum_mul   = (state_q == SUM_MUL);
		cmd.sum_acc   = (state_q == SUM_ACC);
		cmd.fin_mul   = (state_q == FIN_MUL);
		cmd.out_load  = (state_q == FIN_OUT) && stat.out_free;
		cmd.run_end   = (k_next == n_q);
	end

	// A run always holds at least one term and never more than the store.
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> (n_q != '0 && n_q <= CW'(mcd_pkg::MAX_TERMS)))
		else $error("term count out of range during a run");

	// The order index stays below the term count.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> (k_next <= n_q))
		else $error("order index beyond term count");

	// Sum reads address only loaded entries at or above the current order.
	a_sum_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SUM_RD) |-> (p_q < n_q && p_q > CW'(k_q)))
		else $error("sum index out of range");

	// The load count never exceeds the store depth.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_q <= CW'(mcd_pkg::MAX_TERMS))
		else $error("load count beyond store depth");

endmodule

// ===== design/mie_legendre_cd_coefficients_unit.sv =====
// Mie C/D coefficient unit: loads one (a_n, b_n) word per cycle; after the final
// word, emits C_k and D_k for k = 0..N-1; each order runs a lead divide for k > 0
// (one quotient bit per cycle, 41 steps), a sum loop of read, multiply and
// accumulate steps over two terms per pass, then a final scale and output.
// Inputs stall while a run is computed. Asynchronous active-low reset clears
// the controller and result valid; the coefficient store is not cleared.
module mie_legendre_cd_coefficients_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] a_real,
	input  logic signed [31:0] a_imag,
	input  logic signed [31:0] b_real,
	input  logic signed [31:0] b_imag,
	input  logic               final_term,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [5:0]         order_index,
	output logic signed [47:0] c_real,
	output logic signed [47:0] c_imag,
	output logic signed [47:0] d_real,
	output logic signed [47:0] d_imag,
	output logic               run_end
);

	mcd_pkg::cmd_t  cmd;
	mcd_pkg::stat_t stat;

	mcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.final_term(final_term),
		.item_stall(item_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mcd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.a_real      (a_real),
		.a_imag      (a_imag),
		.b_real      (b_real),
		.b_imag      (b_imag),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.order_index (order_index),
		.c_real      (c_real),
		.c_imag      (c_imag),
		.d_real      (d_real),
		.d_imag      (d_imag),
		.run_end     (run_end)
	);

endmodule
